>>> sv/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  // Field and datapath widths.
  localparam int DW   = 24;  // raw conversion word
  localparam int CW   = 16;  // calibration word
  localparam int DTW  = 25;  // temperature difference dT
  localparam int PW   = 42;  // dT times a calibration word
  localparam int SQW  = 50;  // dT squared
  localparam int TW   = 20;  // internal temperature
  localparam int T2W  = 18;  // second-order temperature term
  localparam int SQ2W = 40;  // square of a temperature distance
  localparam int OW   = 40;  // offset and sensitivity
  localparam int LOW_W = 20; // low slice of the sensitivity for the split multiply
  localparam int PLW  = 44;  // low partial product
  localparam int PHW  = 45;  // high partial product
  localparam int MW   = 64;  // full pressure product
  localparam int QW   = 44;  // scaled product minus offset
  localparam int TOUT = 19;  // output temperature
  localparam int POUT = 32;  // output pressure
  localparam int BW   = 2;   // correction band
  localparam int IDXW = 3;   // configuration index

  // Configuration register indexes.
  localparam logic [IDXW-1:0] CFG_C1 = 3'd0;
  localparam logic [IDXW-1:0] CFG_C2 = 3'd1;
  localparam logic [IDXW-1:0] CFG_C3 = 3'd2;
  localparam logic [IDXW-1:0] CFG_C4 = 3'd3;
  localparam logic [IDXW-1:0] CFG_C5 = 3'd4;
  localparam logic [IDXW-1:0] CFG_C6 = 3'd5;

  // Correction band codes.
  localparam logic [BW-1:0] BAND_NONE = 2'd0;
  localparam logic [BW-1:0] BAND_LOW  = 2'd1;
  localparam logic [BW-1:0] BAND_VLOW = 2'd2;

  // Temperature thresholds in hundredths of a degree.
  localparam logic signed [TW-1:0] TEMP_REF      = 20'sd2000;
  localparam logic signed [TW-1:0] TEMP_VLOW     = -20'sd1500;
  localparam logic signed [TW-1:0] TEMP_VLOW_OFS = 20'sd1500;

  // Pressure saturation limits.
  localparam logic [POUT-1:0] PRES_MAX = 32'h7FFF_FFFF;
  localparam logic [POUT-1:0] PRES_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [CW-1:0] c1;
    logic [CW-1:0] c2;
    logic [CW-1:0] c3;
    logic [CW-1:0] c4;
    logic [CW-1:0] c5;
    logic [CW-1:0] c6;
  } bsc_cal_t;

  // First-order results handed to the correction stages.
  typedef struct packed {
    logic                 valid;
    logic [DW-1:0]        d1;
    logic signed [TW-1:0] temp;
    logic [T2W-1:0]       t2;
    logic signed [OW-1:0] off;
    logic signed [OW-1:0] sens;
  } bsc_first_t;

  // Corrected results handed to the pressure stages.
  typedef struct packed {
    logic                 valid;
    logic [DW-1:0]        d1;
    logic signed [TW-1:0] temp;
    logic [BW-1:0]        band;
    logic signed [OW-1:0] off;
    logic signed [OW-1:0] sens;
  } bsc_corr_t;

endpackage

`default_nettype wire

>>> sv/bsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_front
  import bsc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_take,
  input  wire logic [DW-1:0] in_d1,
  input  wire logic [DW-1:0] in_d2,
  input  wire bsc_cal_t      cal,
  output bsc_first_t         first
);

  // Stage 1: temperature difference.
  logic                  v1_r;
  logic [DW-1:0]         d1_1_r;
  logic signed [DTW-1:0] dt_r;
  logic signed [DTW-1:0] dt_nxt;

  // Stage 2: products of dT.
  logic                  v2_r;
  logic [DW-1:0]         d1_2_r;
  logic signed [PW-1:0]  p6_r, p4_r, p3_r;
  logic signed [PW-1:0]  p6_nxt, p4_nxt, p3_nxt;
  logic signed [SQW-1:0] sq_r, sq_nxt;

  // Stage 3: first-order temperature, offset and sensitivity.
  logic                  v3_r;
  logic [DW-1:0]         d1_3_r;
  logic signed [TW-1:0]  temp_r, temp_nxt;
  logic [T2W-1:0]        t2_r, t2_nxt;
  logic signed [OW-1:0]  off_r, off_nxt;
  logic signed [OW-1:0]  sens_r, sens_nxt;

  always_comb begin
    dt_nxt = $signed({1'b0, in_d2}) - $signed({1'b0, cal.c5, 8'b0});
    p6_nxt = PW'(dt_r) * PW'($signed({1'b0, cal.c6}));
    p4_nxt = PW'(dt_r) * PW'($signed({1'b0, cal.c4}));
    p3_nxt = PW'(dt_r) * PW'($signed({1'b0, cal.c3}));
    sq_nxt = SQW'(dt_r) * SQW'(dt_r);
    temp_nxt = TEMP_REF + TW'(p6_r >>> 23);
    off_nxt  = $signed({8'b0, cal.c2, 16'b0}) + OW'(p4_r >>> 7);
    sens_nxt = $signed({9'b0, cal.c1, 15'b0}) + OW'(p3_r >>> 8);
    // The square is never negative, so the floor shift is a plain slice.
    t2_nxt = sq_r[48:31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_1_r <= in_d1;
    dt_r   <= dt_nxt;
    d1_2_r <= d1_1_r;
    p6_r   <= p6_nxt;
    p4_r   <= p4_nxt;
    p3_r   <= p3_nxt;
    sq_r   <= sq_nxt;
    d1_3_r <= d1_2_r;
    temp_r <= temp_nxt;
    t2_r   <= t2_nxt;
    off_r  <= off_nxt;
    sens_r <= sens_nxt;
  end

  always_comb begin
    first.valid = v3_r;
    first.d1    = d1_3_r;
    first.temp  = temp_r;
    first.t2    = t2_r;
    first.off   = off_r;
    first.sens  = sens_r;
  end

endmodule

`default_nettype wire

>>> sv/bsc_corr.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_corr
  import bsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire bsc_first_t first,
  output bsc_corr_t       corr
);

  logic signed [TW-1:0] temp_in;
  logic signed [TW-1:0] dist_a, dist_b;

  // Stage 4: band decision and squared distances.
  logic                 v4_r;
  logic [DW-1:0]        d1_4_r;
  logic signed [TW-1:0] temp4_r;
  logic [T2W-1:0]       t2_4_r;
  logic signed [OW-1:0] off4_r, sens4_r;
  logic [BW-1:0]        band4_r, band_nxt;
  logic [SQ2W-1:0]      aa_r, aa_nxt;
  logic [SQ2W-1:0]      bb_r, bb_nxt;

  // Stage 5: correction terms and corrected temperature.
  logic                 v5_r;
  logic [DW-1:0]        d1_5_r;
  logic signed [TW-1:0] temp5_r, temp5_nxt;
  logic signed [OW-1:0] off5_r, sens5_r;
  logic [BW-1:0]        band5_r;
  logic [OW-1:0]        off2_r, off2_nxt;
  logic [OW-1:0]        sens2_r, sens2_nxt;
  logic [SQ2W-1:0]      aa5, bb7, bb11;

  // Stage 6: corrected offset and sensitivity.
  logic                 v6_r;
  logic [DW-1:0]        d1_6_r;
  logic signed [TW-1:0] temp6_r;
  logic [BW-1:0]        band6_r;
  logic signed [OW-1:0] off6_r, off6_nxt;
  logic signed [OW-1:0] sens6_r, sens6_nxt;

  always_comb begin
    temp_in = first.temp;
    dist_a  = temp_in - TEMP_REF;
    dist_b  = temp_in + TEMP_VLOW_OFS;
    aa_nxt  = SQ2W'(dist_a) * SQ2W'(dist_a);
    bb_nxt  = SQ2W'(dist_b) * SQ2W'(dist_b);
    priority if (temp_in < TEMP_VLOW) begin
      band_nxt = BAND_VLOW;
    end else if (temp_in < TEMP_REF) begin
      band_nxt = BAND_LOW;
    end else begin
      band_nxt = BAND_NONE;
    end
  end

  always_comb begin
    aa5  = aa_r * 40'd5;
    bb7  = bb_r * 40'd7;
    bb11 = bb_r * 40'd11;
    off2_nxt  = '0;
    sens2_nxt = '0;
    temp5_nxt = temp4_r;
    // Each halving or quartering is floored on its own term.
    if (band4_r != BAND_NONE) begin
      off2_nxt  = {1'b0, aa5[SQ2W-1:1]};
      sens2_nxt = {2'b0, aa5[SQ2W-1:2]};
      temp5_nxt = temp4_r - $signed({2'b0, t2_4_r});
    end
    if (band4_r == BAND_VLOW) begin
      off2_nxt  = off2_nxt + bb7;
      sens2_nxt = sens2_nxt + {1'b0, bb11[SQ2W-1:1]};
    end
  end

  always_comb begin
    off6_nxt  = off5_r - $signed(off2_r);
    sens6_nxt = sens5_r - $signed(sens2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v4_r <= first.valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_4_r  <= first.d1;
    temp4_r <= temp_in;
    t2_4_r  <= first.t2;
    off4_r  <= first.off;
    sens4_r <= first.sens;
    band4_r <= band_nxt;
    aa_r    <= aa_nxt;
    bb_r    <= bb_nxt;

    d1_5_r  <= d1_4_r;
    temp5_r <= temp5_nxt;
    off5_r  <= off4_r;
    sens5_r <= sens4_r;
    band5_r <= band4_r;
    off2_r  <= off2_nxt;
    sens2_r <= sens2_nxt;

    d1_6_r  <= d1_5_r;
    temp6_r <= temp5_r;
    band6_r <= band5_r;
    off6_r  <= off6_nxt;
    sens6_r <= sens6_nxt;
  end

  always_comb begin
    corr.valid = v6_r;
    corr.d1    = d1_6_r;
    corr.temp  = temp6_r;
    corr.band  = band6_r;
    corr.off   = off6_r;
    corr.sens  = sens6_r;
  end

endmodule

`default_nettype wire

>>> sv/bsc_pres.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_pres
  import bsc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire bsc_corr_t    corr,
  output logic              res_valid,
  output logic [TOUT-1:0]   res_temp,
  output logic [POUT-1:0]   res_pres,
  output logic [BW-1:0]     res_band
);

  // Stage 7: the D1 times SENS product as two partial products.
  logic                    v7_r;
  logic signed [TW-1:0]    temp7_r;
  logic [BW-1:0]           band7_r;
  logic signed [OW-1:0]    off7_r;
  logic [PLW-1:0]          pl_r, pl_nxt;
  logic signed [PHW-1:0]   ph_r, ph_nxt;
  logic signed [OW-LOW_W-1:0] sens_hi;

  // Stage 8: full product.
  logic                    v8_r;
  logic signed [TW-1:0]    temp8_r;
  logic [BW-1:0]           band8_r;
  logic signed [OW-1:0]    off8_r;
  logic signed [MW-1:0]    prod_r, prod_nxt;

  // Stage 9: scaled product minus offset.
  logic                    v9_r;
  logic signed [TW-1:0]    temp9_r;
  logic [BW-1:0]           band9_r;
  logic signed [QW-1:0]    q_r, q_nxt;

  // Stage 10: output word.
  logic                    v10_r;
  logic [TOUT-1:0]         temp10_r;
  logic [BW-1:0]           band10_r;
  logic [POUT-1:0]         pres_r, pres_nxt;
  logic signed [QW-1:0]    scaled;
  logic                    sat_hi, sat_lo;

  always_comb begin
    sens_hi = corr.sens[OW-1:LOW_W];
    pl_nxt  = PLW'(corr.d1) * PLW'(corr.sens[LOW_W-1:0]);
    ph_nxt  = PHW'($signed({1'b0, corr.d1})) * PHW'(sens_hi);
    // The true product fits 64 signed bits, so wrapping here is harmless.
    prod_nxt = (MW'(ph_r) <<< LOW_W) + $signed({20'b0, pl_r});
    q_nxt    = QW'(prod_r >>> 21) - QW'(off8_r);
    scaled   = q_r >>> 15;
    sat_hi   = !scaled[QW-1] && (|scaled[QW-2:POUT-1]);
    sat_lo   = scaled[QW-1] && !(&scaled[QW-2:POUT-1]);
    priority if (sat_hi) begin
      pres_nxt = PRES_MAX;
    end else if (sat_lo) begin
      pres_nxt = PRES_MIN;
    end else begin
      pres_nxt = scaled[POUT-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else begin
      v7_r  <= corr.valid;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    temp7_r  <= corr.temp;
    band7_r  <= corr.band;
    off7_r   <= corr.off;
    pl_r     <= pl_nxt;
    ph_r     <= ph_nxt;

    temp8_r  <= temp7_r;
    band8_r  <= band7_r;
    off8_r   <= off7_r;
    prod_r   <= prod_nxt;

    temp9_r  <= temp8_r;
    band9_r  <= band8_r;
    q_r      <= q_nxt;

    temp10_r <= temp9_r[TOUT-1:0];
    band10_r <= band9_r;
    pres_r   <= pres_nxt;
  end

  assign res_valid = v10_r;
  assign res_temp  = temp10_r;
  assign res_pres  = pres_r;
  assign res_band  = band10_r;

endmodule

`default_nettype wire

>>> sv/baro_sensor_compensation_unit.sv
// A word accepted at one clock edge shows its result on out_valid once it has passed every stage.
// Throughput: one word per cycle; busy stays low, so start may be held high every cycle.
// The ten register stages of the multiplier chain set the latency; each stage holds one word.
// Results come out for exactly one cycle each and cannot be held off by the receiver.
// Reset (synchronous, active low) clears every stage's valid bit and the calibration words.
`timescale 1ns / 1ps
`default_nettype none

module baro_sensor_compensation_unit
  import bsc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [DW-1:0]          in_pressure_raw,
  input  wire logic [DW-1:0]          in_temperature_raw,
  output logic                        out_valid,
  output logic signed [TOUT-1:0]      out_temperature_centi,
  output logic signed [POUT-1:0]      out_pressure_centi_mbar,
  output logic [BW-1:0]               out_correction_band,
  input  wire logic                   cfg_we,
  input  wire logic [IDXW-1:0]        cfg_index,
  input  wire logic [CW-1:0]          cfg_wdata
);

  bsc_cal_t   cal_r, cal_nxt;
  bsc_first_t first;
  bsc_corr_t  corr;
  logic       take;
  logic [TOUT-1:0] res_temp;
  logic [POUT-1:0] res_pres;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_C1:  cal_nxt.c1 = cfg_wdata;
        CFG_C2:  cal_nxt.c2 = cfg_wdata;
        CFG_C3:  cal_nxt.c3 = cfg_wdata;
        CFG_C4:  cal_nxt.c4 = cfg_wdata;
        CFG_C5:  cal_nxt.c5 = cfg_wdata;
        CFG_C6:  cal_nxt.c6 = cfg_wdata;
        default: cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  bsc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_take (take),
    .in_d1 (in_pressure_raw),
    .in_d2 (in_temperature_raw),
    .cal   (cal_r),
    .first (first)
  );

  bsc_corr u_corr (
    .clk   (clk),
    .rst_n (rst_n),
    .first (first),
    .corr  (corr)
  );

  bsc_pres u_pres (
    .clk       (clk),
    .rst_n     (rst_n),
    .corr      (corr),
    .res_valid (out_valid),
    .res_temp  (res_temp),
    .res_pres  (res_pres),
    .res_band  (out_correction_band)
  );

  assign out_temperature_centi   = $signed(res_temp);
  assign out_pressure_centi_mbar = $signed(res_pres);

endmodule

`default_nettype wire

>>> sv/bsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_checker
  import bsc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   out_valid,
  input wire logic signed [TOUT-1:0] out_temperature_centi,
  input wire logic [BW-1:0]          out_correction_band
);

  // Every accepted word comes out on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##10 out_valid)
    else $error("accepted word did not come out after ten cycles");

  // No result without a matching accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##10 !out_valid)
    else $error("result without a matching accepted word");

  // Without correction the temperature is at or above the reference.
  a_band_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_correction_band == BAND_NONE) |-> (out_temperature_centi >= 19'sd2000))
    else $error("uncorrected band with a temperature below the reference");

  // A corrected temperature only moves further down, so it stays below the threshold of its band.
  a_band_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_correction_band == BAND_LOW) |-> (out_temperature_centi < 19'sd2000))
    else $error("low band with a temperature at or above the reference");

  a_band_vlow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_correction_band == BAND_VLOW) |-> (out_temperature_centi < -19'sd1500))
    else $error("very low band with a temperature above the lower threshold");

endmodule

bind baro_sensor_compensation_unit bsc_checker u_bsc_checker (.*);

`default_nettype wire

>>> dv/baro_compensation_checker.sv
`timescale 1ns / 1ps

module baro_compensation_checker
  import bsc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic                   busy,
  input  wire logic [DW-1:0]          in_pressure_raw,
  input  wire logic [DW-1:0]          in_temperature_raw,
  input  wire logic                   out_valid,
  input  wire logic signed [TOUT-1:0] out_temperature_centi,
  input  wire logic signed [POUT-1:0] out_pressure_centi_mbar,
  input  wire logic [BW-1:0]          out_correction_band,
  input  wire logic                   cfg_we,
  input  wire logic [IDXW-1:0]        cfg_index,
  input  wire logic [CW-1:0]          cfg_wdata,
  input  wire logic                   end_of_test,
  output int                          pending_count,
  output int                          fail_count
);

  localparam int MAX_PRINTS = 20;

  typedef struct packed {
    logic signed [TOUT-1:0] temp;
    logic signed [POUT-1:0] pres;
    logic [BW-1:0]          band;
  } reading_t;

  bsc_cal_t cal_words;
  reading_t pending_readings [$];
  reading_t want;
  int       readings_checked;
  int       reg_writes;
  int       band_seen [4];
  bit       wrapped_up;

  // Full-width compensation of one raw pair; >>> on longint is a floor shift.
  function automatic reading_t compensate(input bsc_cal_t cal, input logic [DW-1:0] d1,
                                          input logic [DW-1:0] d2);
    longint c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, t2, off2, sens2, gap, pres, temp_out;
    reading_t r;
    c1 = longint'(cal.c1);
    c2 = longint'(cal.c2);
    c3 = longint'(cal.c3);
    c4 = longint'(cal.c4);
    c5 = longint'(cal.c5);
    c6 = longint'(cal.c6);
    dt   = longint'(d2) - (c5 <<< 8);
    temp = 2000 + ((dt * c6) >>> 23);
    off  = (c2 <<< 16) + ((c4 * dt) >>> 7);
    sens = (c1 <<< 15) + ((c3 * dt) >>> 8);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    r.band = BAND_NONE;
    // The band is chosen on the first-order temperature, before T2 is removed.
    if (temp < TEMP_REF) begin
      gap    = temp - TEMP_REF;
      r.band = BAND_LOW;
      t2     = (dt * dt) >>> 31;
      off2   = 5 * gap * gap / 2;
      sens2  = 5 * gap * gap / 4;
      if (temp < TEMP_VLOW) begin
        gap    = temp + TEMP_VLOW_OFS;
        r.band = BAND_VLOW;
        off2   = off2 + 7 * gap * gap;
        sens2  = sens2 + 11 * gap * gap / 2;
      end
    end
    off  = off - off2;
    sens = sens - sens2;
    pres = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    if (pres > longint'($signed(PRES_MAX)))
      pres = longint'($signed(PRES_MAX));
    if (pres < longint'($signed(PRES_MIN)))
      pres = longint'($signed(PRES_MIN));
    temp_out = temp - t2;
    r.temp = temp_out[TOUT-1:0];
    r.pres = pres[POUT-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS)
      $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cal_words = '0;
      pending_readings.delete();
    end else begin
      // Compare before queuing, so a word accepted at this edge cannot match itself.
      if (out_valid === 1'b1) begin
        if (pending_readings.size() == 0) begin
          report_mismatch("result word with no reading pending");
        end else begin
          want = pending_readings.pop_front();
          if (out_temperature_centi !== want.temp)
            report_mismatch($sformatf("temperature got %0d, expected %0d",
                                      out_temperature_centi, want.temp));
          if (out_pressure_centi_mbar !== want.pres)
            report_mismatch($sformatf("pressure got %0d, expected %0d",
                                      out_pressure_centi_mbar, want.pres));
          if (out_correction_band !== want.band)
            report_mismatch($sformatf("band got %0d, expected %0d",
                                      out_correction_band, want.band));
          band_seen[want.band]++;
          readings_checked++;
        end
      end
      if (start && !busy)
        pending_readings.push_back(compensate(cal_words, in_pressure_raw, in_temperature_raw));
      if (cfg_we) begin
        reg_writes++;
        case (cfg_index)
          CFG_C1: cal_words.c1 = cfg_wdata;
          CFG_C2: cal_words.c2 = cfg_wdata;
          CFG_C3: cal_words.c3 = cfg_wdata;
          CFG_C4: cal_words.c4 = cfg_wdata;
          CFG_C5: cal_words.c5 = cfg_wdata;
          CFG_C6: cal_words.c6 = cfg_wdata;
          default: ;
        endcase
      end
      if (end_of_test && !wrapped_up) begin
        wrapped_up = 1'b1;
        if (pending_readings.size() != 0)
          report_mismatch($sformatf("%0d readings never came out", pending_readings.size()));
        $display("Checked %0d compensated readings after %0d register writes.",
                 readings_checked, reg_writes);
        $display("Correction bands seen: none %0d, low %0d, very low %0d.",
                 band_seen[BAND_NONE], band_seen[BAND_LOW], band_seen[BAND_VLOW]);
      end
    end
    pending_count <= pending_readings.size();
  end

endmodule

>>> dv/baro_sensor_compensation_unit_tb.sv
`timescale 1ns / 1ps

module baro_sensor_compensation_unit_tb;
  import bsc_pkg::*;

  localparam int NUM_SETS      = 6;
  localparam int WORDS_PER_SET = 125;
  localparam int LATENCY       = 10;
  localparam logic [DW-1:0] D_MAX     = {DW{1'b1}};
  localparam logic [DW-1:0] D1_TYPICAL = 24'd9085466;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [DW-1:0]          in_pressure_raw = '0;
  logic [DW-1:0]          in_temperature_raw = '0;
  logic                   out_valid;
  logic signed [TOUT-1:0] out_temperature_centi;
  logic signed [POUT-1:0] out_pressure_centi_mbar;
  logic [BW-1:0]          out_correction_band;
  logic                   cfg_we = 1'b0;
  logic [IDXW-1:0]        cfg_index = '0;
  logic [CW-1:0]          cfg_wdata = '0;
  logic                   end_of_test = 1'b0;
  int                     pending_count;
  int                     fail_count;

  bsc_cal_t cal_now;
  int       idle_pct;

  baro_sensor_compensation_unit i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_pressure_raw         (in_pressure_raw),
    .in_temperature_raw      (in_temperature_raw),
    .out_valid               (out_valid),
    .out_temperature_centi   (out_temperature_centi),
    .out_pressure_centi_mbar (out_pressure_centi_mbar),
    .out_correction_band     (out_correction_band),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  baro_compensation_checker i_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_pressure_raw         (in_pressure_raw),
    .in_temperature_raw      (in_temperature_raw),
    .out_valid               (out_valid),
    .out_temperature_centi   (out_temperature_centi),
    .out_pressure_centi_mbar (out_pressure_centi_mbar),
    .out_correction_band     (out_correction_band),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .end_of_test             (end_of_test),
    .pending_count           (pending_count),
    .fail_count              (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic cfg_write(input logic [IDXW-1:0] idx, input logic [CW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Loads all six calibration words, then scribbles on the unused indexes,
  // which must leave them untouched.
  task automatic write_cal(input bsc_cal_t c);
    cal_now = c;
    cfg_write(CFG_C1, c.c1);
    cfg_write(CFG_C2, c.c2);
    cfg_write(CFG_C3, c.c3);
    cfg_write(CFG_C4, c.c4);
    cfg_write(CFG_C5, c.c5);
    cfg_write(CFG_C6, c.c6);
    for (int k = int'(CFG_C6) + 1; k < (1 << IDXW); k++)
      cfg_write(IDXW'(k), CW'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic send_reading(input logic [DW-1:0] d1, input logic [DW-1:0] d2);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_pressure_raw    <= d1;
    in_temperature_raw <= d2;
    do @(posedge clk); while (busy);
  endtask

  // Raw temperature at a given distance from the reference reading, clamped to the field.
  function automatic logic [DW-1:0] near_reference(input longint offset);
    longint v;
    v = (longint'(cal_now.c5) <<< 8) + offset;
    if (v < 0)
      v = 0;
    if (v > longint'(D_MAX))
      v = longint'(D_MAX);
    return v[DW-1:0];
  endfunction

  // Smallest raw temperature whose first-order temperature reaches the target.
  function automatic logic [DW-1:0] d2_at_temp(input int target);
    if (cal_now.c6 == 0)
      return near_reference(0);
    return near_reference(-((longint'(2000 - target) <<< 23) / longint'(cal_now.c6)));
  endfunction

  task automatic run_directed();
    send_reading('0, '0);
    send_reading(D_MAX, D_MAX);
    send_reading(D_MAX, '0);
    send_reading('0, D_MAX);
    send_reading(24'h555555, 24'hAAAAAA);
    send_reading(24'hAAAAAA, 24'h555555);
    // Both sides of the 20 C and -15 C thresholds.
    send_reading(D1_TYPICAL, d2_at_temp(2000));
    send_reading(D1_TYPICAL, d2_at_temp(2000) - DW'(1));
    send_reading(D1_TYPICAL, d2_at_temp(2000) + DW'(1));
    send_reading(D1_TYPICAL, d2_at_temp(-1500));
    send_reading(D1_TYPICAL, d2_at_temp(-1500) - DW'(1));
    send_reading(D_MAX, d2_at_temp(-1500) - DW'(1));
  endtask

  // Most raw temperatures land near the reference so that every band gets hit.
  task automatic send_random_reading();
    logic [DW-1:0] d2;
    int            span;
    if ($urandom_range(3) == 0) begin
      d2 = DW'($urandom);
    end else begin
      span = 1 << $urandom_range(23);
      d2   = near_reference(longint'($urandom_range(2 * span)) - span);
    end
    send_reading(DW'($urandom), d2);
  endtask

  function automatic bsc_cal_t random_cal();
    bsc_cal_t c;
    c.c1 = CW'($urandom);
    c.c2 = CW'($urandom);
    c.c3 = CW'($urandom);
    c.c4 = CW'($urandom);
    c.c5 = CW'($urandom);
    c.c6 = CW'($urandom);
    return c;
  endfunction

  initial begin
    bsc_cal_t set_cal;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int s = 0; s < NUM_SETS; s++) begin
      case (s)
        0: set_cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        2: set_cal = '{c1: '1, c2: '1, c3: '1, c4: '1, c5: '1, c6: '1};
        4: set_cal = '0;
        // Large reference and coefficient drive readings far below the reference deep into the very low band.
        5: set_cal = '{c1: '0, c2: '1, c3: '0, c4: '1, c5: '1, c6: '1};
        default: set_cal = random_cal();
      endcase
      idle_pct = (s < 2) ? 16 : (s < 4) ? 78 : 0;
      wait_drained();
      write_cal(set_cal);
      if (s == 0)
        run_directed();
      repeat (WORDS_PER_SET) send_random_reading();
    end
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("PASS baro_sensor_compensation_unit");
    else
      $display("FAIL baro_sensor_compensation_unit");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d readings still pending.", pending_count);
    $display("FAIL baro_sensor_compensation_unit");
    $finish;
  end

endmodule

>>> sim.f
sv/bsc_pkg.sv
sv/bsc_front.sv
sv/bsc_corr.sv
sv/bsc_pres.sv
sv/baro_sensor_compensation_unit.sv
sv/bsc_checker.sv
dv/baro_compensation_checker.sv
dv/baro_sensor_compensation_unit_tb.sv
